@@ hdl/dtfp_pkg.sv @@
// Types, constants and decode functions of the delimited text field parser.
package dtfp_pkg;

  // Default depth of the trailing blank hold.
  localparam int unsigned BLANK_HOLD_DEPTH_DEF = 8;

  // Port widths.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BAD_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned OUT_DATA_W = BAD_W + BYTE_W;
  localparam int unsigned OUT_USER_W = 3;

  typedef logic [BYTE_W-1:0] byte_t;

  // Character constants.
  localparam byte_t CH_NUL   = 8'h00;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_NL    = 8'h0A;
  localparam byte_t CH_VT    = 8'h0B;
  localparam byte_t CH_FF    = 8'h0C;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_HASH  = 8'h23;

  // Configuration reset values.
  localparam byte_t SEP_RST   = 8'd44;
  localparam byte_t QUOTE_RST = 8'd34;
  localparam byte_t ESC_RST   = 8'd92;

  // Event kinds of a result item.
  typedef enum logic [1:0] {
    EV_DATA     = 2'd0,
    EV_END_CELL = 2'd1,
    EV_END_ROW  = 2'd2,
    EV_BAD      = 2'd3
  } ev_kind_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIELD_SEP    = 3'd0,
    REG_QUOTE        = 3'd1,
    REG_ESCAPE       = 3'd2,
    REG_STRIP        = 3'd3,
    REG_DOUBLE_QUOTE = 3'd4,
    REG_BAD_IS_ERR   = 3'd5,
    REG_HEADER       = 3'd6
  } cfg_reg_t;

  // Parse states, one-hot.
  typedef enum logic [10:0] {
    ST_START_FILE     = 11'b000_0000_0001,
    ST_START_ROW      = 11'b000_0000_0010,
    ST_EOL            = 11'b000_0000_0100,
    ST_ESC_EOL        = 11'b000_0000_1000,
    ST_COMMENT        = 11'b000_0001_0000,
    ST_START_CELL     = 11'b000_0010_0000,
    ST_IN_CELL        = 11'b000_0100_0000,
    ST_ESC_IN_CELL    = 11'b000_1000_0000,
    ST_IN_QUOTED      = 11'b001_0000_0000,
    ST_ESC_IN_QUOTED  = 11'b010_0000_0000,
    ST_QUOTE_IN_QUOTED = 11'b100_0000_0000
  } pstate_t;

  // What one input byte does to the cell and row.
  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_ADD      = 3'd1,
    ACT_END_CELL = 3'd2,
    ACT_END_ROW  = 3'd3,
    ACT_BAD      = 3'd4
  } act_t;

  typedef struct packed {
    byte_t sep;
    byte_t quote;
    byte_t esc;
    logic  strip;
    logic  dq;
    logic  bad_err;
    logic  header;
  } cfg_t;

  // Decoded action, the byte it carries and the next parse state.
  typedef struct packed {
    act_t    act;
    byte_t   b;
    pstate_t st;
  } dec_t;

  function automatic logic is_blank(byte_t c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_eol(byte_t c);
    return (c == CH_NL) || (c == CH_CR);
  endfunction

  // A byte at the start of a cell.
  function automatic dec_t field_open_dec(byte_t c, cfg_t cfg);
    dec_t d;
    d.act = ACT_NONE;
    d.b   = c;
    d.st  = ST_START_CELL;
    priority if (is_eol(c) || (c == CH_NUL)) begin
      d.act = ACT_END_ROW;
      d.st  = (c == CH_NUL) ? ST_START_ROW : ST_EOL;
    end else if (c == cfg.quote) begin
      d.st = ST_IN_QUOTED;
    end else if (c == cfg.esc) begin
      d.st = ST_ESC_IN_CELL;
    end else if (((c == CH_SPACE) || (c == CH_TAB)) && cfg.strip) begin
      d.st = ST_START_CELL;
    end else if (c == cfg.sep) begin
      d.act = ACT_END_CELL;
    end else begin
      d.act = ACT_ADD;
      d.st  = ST_IN_CELL;
    end
    return d;
  endfunction

  // A byte at the start of a row: blank lines and comments are skipped.
  function automatic dec_t line_open_dec(byte_t c, cfg_t cfg);
    dec_t d;
    d.act = ACT_NONE;
    d.b   = c;
    d.st  = ST_START_ROW;
    priority if (c == CH_NUL) begin
      d.st = ST_START_ROW;
    end else if (is_eol(c)) begin
      d.st = ST_EOL;
    end else if (c == CH_HASH) begin
      d.st = ST_COMMENT;
    end else begin
      d = field_open_dec(c, cfg);
    end
    return d;
  endfunction

  // A byte inside an unquoted cell; plain bytes keep the current state.
  function automatic dec_t in_cell(byte_t c, cfg_t cfg, pstate_t cur);
    dec_t d;
    d.act = ACT_ADD;
    d.b   = c;
    d.st  = cur;
    priority if (is_eol(c) || (c == CH_NUL)) begin
      d.act = ACT_END_ROW;
      d.st  = (c == CH_NUL) ? ST_START_ROW : ST_EOL;
    end else if (c == cfg.esc) begin
      d.act = ACT_NONE;
      d.st  = ST_ESC_IN_CELL;
    end else if (c == cfg.sep) begin
      d.act = ACT_END_CELL;
      d.st  = ST_START_CELL;
    end else begin
      d.act = ACT_ADD;
    end
    return d;
  endfunction

endpackage

@@ hdl/delimited_text_field_parser.sv @@
// Delimited text field parser: byte-wide parse state machine with a result sequencer.
//
// Usage: text bytes enter on the in_ stream, one per item; a zero byte ends the input.
// Each byte is decoded in the cycle it is accepted and its results are loaded into a
// result register; the out_ stream then delivers them one per cycle, the final one of
// the byte marked by out_tlast. A byte may give no result, one, two (end of cell and
// end of row) or a flush of held trailing blanks followed by the byte itself, at most
// BLANK_HOLD_DEPTH + 1 results.
// Latency: a result is valid the cycle after its byte is accepted.
// Throughput: one byte per cycle while each byte gives at most one result; a byte that
// gives more results holds the result register until its last result is taken, and the
// next byte is taken in that cycle. Bytes that give no result pass at one per cycle.
// When the receiver stalls, the result register holds and in_tready stays low until the
// final pending result is taken. The configuration port writes a register; the user
// must write it only while the block is idle, which the block itself does not enforce.
// Reset (rst_n low at a clock edge) returns the parser to start of file, clears the
// pending results, the held blank count and the bad record count, and reloads the
// configuration defaults. There is no clearing pass.
module delimited_text_field_parser #(
  parameter int unsigned BLANK_HOLD_DEPTH = dtfp_pkg::BLANK_HOLD_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [7:0] in_byte
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dtfp_pkg::BYTE_W-1:0]         in_tdata,
  // out_tdata: [7:0] cell_byte, [39:8] bad record count
  // out_tuser: [1:0] event_kind, [2] in_header
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dtfp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [dtfp_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [dtfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtfp_pkg::BYTE_W-1:0]         cfg_wdata
);
  import dtfp_pkg::*;

  localparam int unsigned CNT_W = $clog2(BLANK_HOLD_DEPTH + 1);
  localparam int unsigned IDX_W = (BLANK_HOLD_DEPTH > 1) ? $clog2(BLANK_HOLD_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BLANK_HOLD_DEPTH);

  // Configuration and parse state.
  cfg_t               cfg_r;
  pstate_t            state_r;
  logic               first_row_r;
  logic               has_content_r;
  logic [CNT_W-1:0]   hold_cnt_r;
  byte_t              hold_r [BLANK_HOLD_DEPTH];
  logic [BAD_W-1:0]   bad_cnt_r;

  // Pending results of the last byte.
  logic               plan_vld_r;
  logic [CNT_W-1:0]   flush_left_r;
  byte_t              flush_r [BLANK_HOLD_DEPTH];
  logic [1:0]         tail_cnt_r;
  ev_kind_t           tail_kind_r [2];
  byte_t              tail_byte_r;
  logic               hdr_r;
  logic [BAD_W-1:0]   plan_bad_r;

  // Next values.
  pstate_t            state_nxt;
  logic               first_row_nxt;
  logic               has_content_nxt;
  logic [CNT_W-1:0]   hold_cnt_nxt;
  logic [BAD_W-1:0]   bad_cnt_nxt;
  logic               hold_push;
  logic               hold_shift;
  logic               ld;
  logic [CNT_W-1:0]   ld_flush;
  logic [1:0]         ld_tail;
  ev_kind_t           ld_kind;
  byte_t              ld_byte;

  dec_t               dec;
  logic               in_acc;
  logic               out_acc;
  logic               cur_last;
  ev_kind_t           cur_kind;
  byte_t              cur_byte;

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign cur_last = (flush_left_r == '0) && (tail_cnt_r == 2'd1);
  assign in_tready = !plan_vld_r || (out_tready && cur_last);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sep     <= SEP_RST;
      cfg_r.quote   <= QUOTE_RST;
      cfg_r.esc     <= ESC_RST;
      cfg_r.strip   <= 1'b0;
      cfg_r.dq      <= 1'b1;
      cfg_r.bad_err <= 1'b0;
      cfg_r.header  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FIELD_SEP:    cfg_r.sep     <= cfg_wdata;
        REG_QUOTE:        cfg_r.quote   <= cfg_wdata;
        REG_ESCAPE:       cfg_r.esc     <= cfg_wdata;
        REG_STRIP:        cfg_r.strip   <= cfg_wdata[0];
        REG_DOUBLE_QUOTE: cfg_r.dq      <= cfg_wdata[0];
        REG_BAD_IS_ERR:   cfg_r.bad_err <= cfg_wdata[0];
        REG_HEADER:       cfg_r.header  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Decode the incoming byte against the parse state.
  always_comb begin
    dec.act = ACT_NONE;
    dec.b   = in_tdata;
    dec.st  = state_r;
    unique case (state_r)
      ST_START_FILE, ST_START_ROW: begin
        dec = line_open_dec(in_tdata, cfg_r);
      end
      ST_START_CELL: begin
        dec = field_open_dec(in_tdata, cfg_r);
      end
      ST_ESC_IN_CELL: begin
        dec.act = ACT_ADD;
        if (is_eol(in_tdata)) begin
          dec.st = ST_ESC_EOL;
        end else begin
          dec.b  = (in_tdata == CH_NUL) ? CH_NL : in_tdata;
          dec.st = ST_IN_CELL;
        end
      end
      ST_ESC_EOL: begin
        if (in_tdata != CH_NUL) begin
          dec = in_cell(in_tdata, cfg_r, state_r);
        end
      end
      ST_IN_CELL: begin
        dec = in_cell(in_tdata, cfg_r, state_r);
      end
      ST_IN_QUOTED: begin
        priority if (in_tdata == CH_NUL) begin
          dec.act = ACT_NONE;
        end else if (in_tdata == cfg_r.esc) begin
          dec.st = ST_ESC_IN_QUOTED;
        end else if (in_tdata == cfg_r.quote) begin
          dec.st = cfg_r.dq ? ST_QUOTE_IN_QUOTED : ST_IN_CELL;
        end else begin
          dec.act = ACT_ADD;
        end
      end
      ST_ESC_IN_QUOTED: begin
        dec.act = ACT_ADD;
        dec.b   = (in_tdata == CH_NUL) ? CH_NL : in_tdata;
        dec.st  = ST_IN_QUOTED;
      end
      ST_QUOTE_IN_QUOTED: begin
        priority if (in_tdata == cfg_r.quote) begin
          dec.act = ACT_ADD;
          dec.st  = ST_IN_QUOTED;
        end else if (in_tdata == cfg_r.sep) begin
          dec.act = ACT_END_CELL;
          dec.st  = ST_START_CELL;
        end else if (is_eol(in_tdata) || (in_tdata == CH_NUL)) begin
          dec.act = ACT_END_ROW;
          dec.st  = (in_tdata == CH_NUL) ? ST_START_ROW : ST_EOL;
        end else begin
          dec.act = ACT_ADD;
          dec.st  = ST_IN_CELL;
        end
      end
      ST_EOL: begin
        priority if (is_eol(in_tdata)) begin
          dec.act = ACT_NONE;
        end else if (in_tdata != CH_NUL) begin
          dec = line_open_dec(in_tdata, cfg_r);
        end else begin
          dec.act = ACT_BAD;
        end
      end
      ST_COMMENT: begin
        if (is_eol(in_tdata)) begin
          dec.st = ST_EOL;
        end
      end
      default: begin
        dec.act = ACT_NONE;
      end
    endcase
  end

  // Apply the action: blank hold, cell and row bookkeeping, bad record count, results to load.
  always_comb begin
    state_nxt       = dec.st;
    first_row_nxt   = first_row_r;
    has_content_nxt = has_content_r;
    hold_cnt_nxt    = hold_cnt_r;
    bad_cnt_nxt     = bad_cnt_r;
    hold_push       = 1'b0;
    hold_shift      = 1'b0;
    ld              = 1'b0;
    ld_flush        = '0;
    ld_tail         = 2'd1;
    ld_kind         = EV_DATA;
    ld_byte         = dec.b;
    unique case (dec.act)
      ACT_ADD: begin
        if (cfg_r.strip && is_blank(dec.b)) begin
          if (has_content_r) begin
            if (hold_cnt_r == DEPTH_C) begin
              // Hold full: the oldest blank goes out, the new one goes in.
              hold_shift = 1'b1;
              ld         = 1'b1;
              ld_byte    = hold_r[0];
            end else begin
              hold_push    = 1'b1;
              hold_cnt_nxt = hold_cnt_r + 1'b1;
            end
          end
        end else begin
          ld              = 1'b1;
          ld_flush        = hold_cnt_r;
          hold_cnt_nxt    = '0;
          has_content_nxt = 1'b1;
        end
      end
      ACT_END_CELL: begin
        ld              = 1'b1;
        ld_kind         = EV_END_CELL;
        ld_byte         = '0;
        hold_cnt_nxt    = '0;
        has_content_nxt = 1'b0;
      end
      ACT_END_ROW: begin
        ld              = 1'b1;
        ld_tail         = 2'd2;
        ld_kind         = EV_END_CELL;
        ld_byte         = '0;
        hold_cnt_nxt    = '0;
        has_content_nxt = 1'b0;
        first_row_nxt   = 1'b0;
      end
      ACT_BAD: begin
        if (bad_cnt_r != '1) begin
          bad_cnt_nxt = bad_cnt_r + 1'b1;
        end
        ld      = cfg_r.bad_err;
        ld_kind = EV_BAD;
        ld_byte = '0;
      end
      default: ;
    endcase
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_START_FILE;
      first_row_r   <= 1'b1;
      has_content_r <= 1'b0;
      hold_cnt_r    <= '0;
      bad_cnt_r     <= '0;
    end else if (in_acc) begin
      state_r       <= state_nxt;
      first_row_r   <= first_row_nxt;
      has_content_r <= has_content_nxt;
      hold_cnt_r    <= hold_cnt_nxt;
      bad_cnt_r     <= bad_cnt_nxt;
    end
  end

  // Trailing blank hold: append at the count, or shift out the oldest when full.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (hold_push) begin
        hold_r[hold_cnt_r[IDX_W-1:0]] <= dec.b;
      end else if (hold_shift) begin
        for (int i = 0; i < int'(BLANK_HOLD_DEPTH) - 1; i++) begin
          hold_r[i] <= hold_r[i+1];
        end
        hold_r[BLANK_HOLD_DEPTH-1] <= dec.b;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_vld_r <= 1'b0;
    end else if (in_acc && ld) begin
      plan_vld_r <= 1'b1;
    end else if (out_acc && cur_last) begin
      plan_vld_r <= 1'b0;
    end
  end

  // Result register contents: load on a byte, step through on each taken item.
  always_ff @(posedge clk) begin
    if (in_acc && ld) begin
      flush_left_r   <= ld_flush;
      flush_r        <= hold_r;
      tail_cnt_r     <= ld_tail;
      tail_kind_r[0] <= ld_kind;
      tail_kind_r[1] <= EV_END_ROW;
      tail_byte_r    <= ld_byte;
      hdr_r          <= first_row_r && cfg_r.header;
      plan_bad_r     <= bad_cnt_nxt;
    end else if (out_acc) begin
      if (flush_left_r != '0) begin
        flush_left_r <= flush_left_r - 1'b1;
        for (int i = 0; i < int'(BLANK_HOLD_DEPTH) - 1; i++) begin
          flush_r[i] <= flush_r[i+1];
        end
      end else begin
        tail_cnt_r     <= tail_cnt_r - 1'b1;
        tail_kind_r[0] <= tail_kind_r[1];
        tail_byte_r    <= '0;
      end
    end
  end

  // Current result: held blanks first, then the byte's own events.
  always_comb begin
    if (flush_left_r != '0) begin
      cur_kind = EV_DATA;
      cur_byte = flush_r[0];
    end else begin
      cur_kind = tail_kind_r[0];
      cur_byte = tail_byte_r;
    end
  end

  assign out_tvalid = plan_vld_r;
  assign out_tdata  = {plan_bad_r, cur_byte};
  assign out_tuser  = {hdr_r, cur_kind};
  assign out_tlast  = cur_last;

  // The hold never counts past its depth.
  a_hold_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    hold_cnt_r <= DEPTH_C)
    else $error("blank hold count beyond depth");

  // Pending results always end with at least one event of the byte itself.
  a_tail_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    plan_vld_r |-> (tail_cnt_r == 2'd1) || (tail_cnt_r == 2'd2))
    else $error("pending results without a closing event");

  // The bad record count never goes down.
  a_bad_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> bad_cnt_r >= $past(bad_cnt_r))
    else $error("bad record count decreased");

  // Only data events carry a byte.
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (cur_kind != EV_DATA)) |-> (cur_byte == '0))
    else $error("marker event with a non-zero byte");

endmodule

@@ sim/delimited_text_field_parser_tb.sv @@
// Self-checking testbench of the delimited text field parser, with its own event predictor.
module delimited_text_field_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtfp_pkg::*;

  localparam int unsigned HOLD_DEPTH = BLANK_HOLD_DEPTH_DEF;

  // One result item as the parser should deliver it.
  typedef struct {
    ev_kind_t         kind;
    byte_t            data_b;
    logic             hdr;
    logic [BAD_W-1:0] bad;
    logic             last;
  } parse_event_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [BYTE_W-1:0]     cfg_wdata = '0;

  delimited_text_field_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Text bytes waiting to be sent and events waiting to arrive.
  byte_t        text_bytes[$];
  parse_event_t expected_events[$];
  parse_event_t byte_events[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  mismatch_count = 0;

  // Shadow of the parser: configuration and parse state.
  cfg_t             cfg_sh;
  pstate_t          ps;
  logic             first_row;
  logic             has_content;
  byte_t            hold[HOLD_DEPTH];
  int unsigned      hold_cnt;
  logic [BAD_W-1:0] bad_cnt;

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Reset, held low at the start only.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Watchdog.
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic space_class(byte_t c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT || c == CH_FF ||
           c == CH_CR;
  endfunction

  function automatic logic line_end(byte_t c);
    return c == CH_NL || c == CH_CR;
  endfunction

  function automatic void push_event(ev_kind_t k, byte_t b);
    parse_event_t e;
    e.kind   = k;
    e.data_b = (k == EV_DATA) ? b : 8'h00;
    e.hdr    = first_row && cfg_sh.header;
    e.bad    = bad_cnt;
    e.last   = 1'b0;
    byte_events.push_back(e);
  endfunction

  // Adds a byte to the cell; with stripping on, blanks after content are held back.
  function automatic void append_cell_byte(byte_t c);
    int unsigned i;
    if (cfg_sh.strip && space_class(c)) begin
      if (!has_content) return;
      if (hold_cnt >= HOLD_DEPTH) begin
        push_event(EV_DATA, hold[0]);
        for (i = 0; i < HOLD_DEPTH - 1; i++) hold[i] = hold[i+1];
        hold_cnt = HOLD_DEPTH - 1;
      end
      hold[hold_cnt] = c;
      hold_cnt++;
      return;
    end
    for (i = 0; i < hold_cnt; i++) push_event(EV_DATA, hold[i]);
    hold_cnt = 0;
    push_event(EV_DATA, c);
    has_content = 1'b1;
  endfunction

  function automatic void close_cell();
    hold_cnt = 0;
    has_content = 1'b0;
    push_event(EV_END_CELL, 8'h00);
  endfunction

  function automatic void close_row(byte_t c);
    close_cell();
    push_event(EV_END_ROW, 8'h00);
    first_row = 1'b0;
    ps = (c != CH_NUL) ? ST_EOL : ST_START_ROW;
  endfunction

  function automatic void at_cell_start(byte_t c);
    if (line_end(c) || c == CH_NUL) begin
      close_row(c);
    end else if (c == cfg_sh.quote) begin
      ps = ST_IN_QUOTED;
    end else if (c == cfg_sh.esc) begin
      ps = ST_ESC_IN_CELL;
    end else if ((c == CH_SPACE || c == CH_TAB) && cfg_sh.strip) begin
      // Leading blank skipped.
    end else if (c == cfg_sh.sep) begin
      close_cell();
    end else begin
      append_cell_byte(c);
      ps = ST_IN_CELL;
    end
  endfunction

  function automatic void at_row_start(byte_t c);
    if (c == CH_NUL) return;
    if (line_end(c)) begin
      ps = ST_EOL;
    end else if (c == CH_HASH) begin
      ps = ST_COMMENT;
    end else begin
      ps = ST_START_CELL;
      at_cell_start(c);
    end
  endfunction

  function automatic void in_plain_cell(byte_t c);
    if (line_end(c) || c == CH_NUL) begin
      close_row(c);
    end else if (c == cfg_sh.esc) begin
      ps = ST_ESC_IN_CELL;
    end else if (c == cfg_sh.sep) begin
      close_cell();
      ps = ST_START_CELL;
    end else begin
      append_cell_byte(c);
    end
  endfunction

  // Works out the events of one accepted byte and queues them.
  function automatic void predict_events(byte_t c);
    byte_events.delete();
    case (ps)
      ST_START_FILE: begin
        ps = ST_START_ROW;
        at_row_start(c);
      end
      ST_START_ROW:  at_row_start(c);
      ST_START_CELL: at_cell_start(c);
      ST_ESC_IN_CELL: begin
        if (line_end(c)) begin
          append_cell_byte(c);
          ps = ST_ESC_EOL;
        end else begin
          append_cell_byte((c != CH_NUL) ? c : CH_NL);
          ps = ST_IN_CELL;
        end
      end
      ST_ESC_EOL: begin
        if (c != CH_NUL) in_plain_cell(c);
      end
      ST_IN_CELL: in_plain_cell(c);
      ST_IN_QUOTED: begin
        if (c == CH_NUL) begin
          // End of input inside quotes is ignored.
        end else if (c == cfg_sh.esc) begin
          ps = ST_ESC_IN_QUOTED;
        end else if (c == cfg_sh.quote) begin
          ps = cfg_sh.dq ? ST_QUOTE_IN_QUOTED : ST_IN_CELL;
        end else begin
          append_cell_byte(c);
        end
      end
      ST_ESC_IN_QUOTED: begin
        append_cell_byte((c != CH_NUL) ? c : CH_NL);
        ps = ST_IN_QUOTED;
      end
      ST_QUOTE_IN_QUOTED: begin
        if (c == cfg_sh.quote) begin
          append_cell_byte(c);
          ps = ST_IN_QUOTED;
        end else if (c == cfg_sh.sep) begin
          close_cell();
          ps = ST_START_CELL;
        end else if (line_end(c) || c == CH_NUL) begin
          close_row(c);
        end else begin
          append_cell_byte(c);
          ps = ST_IN_CELL;
        end
      end
      ST_EOL: begin
        if (line_end(c)) begin
          // Further line ends are swallowed.
        end else if (c != CH_NUL) begin
          ps = ST_START_ROW;
          at_row_start(c);
        end else begin
          if (bad_cnt != '1) bad_cnt++;
          if (cfg_sh.bad_err) push_event(EV_BAD, 8'h00);
        end
      end
      ST_COMMENT: begin
        if (line_end(c)) ps = ST_EOL;
      end
      default: begin
      end
    endcase
    if (byte_events.size() > 0) byte_events[byte_events.size()-1].last = 1'b1;
    foreach (byte_events[i]) expected_events.push_back(byte_events[i]);
  endfunction

  // Driver: offers queued bytes, idling at random, and predicts each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_events(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (text_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= text_bytes.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted event against the oldest expectation.
  always @(posedge clk) begin : monitor
    parse_event_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_events.size() == 0) begin
          mismatch_count++;
          $display("%0t: event with none expected: tdata=%h tuser=%h tlast=%b",
                   $time, out_tdata, out_tuser, out_tlast);
        end else begin
          want = expected_events.pop_front();
          if (out_tuser[1:0] !== want.kind || out_tdata[BYTE_W-1:0] !== want.data_b ||
              out_tuser[2] !== want.hdr || out_tdata[OUT_DATA_W-1:BYTE_W] !== want.bad ||
              out_tlast !== want.last) begin
            mismatch_count++;
            $display("%0t: expected kind=%0d byte=%h hdr=%b bad=%0d last=%b",
                     $time, want.kind, want.data_b, want.hdr, want.bad, want.last);
            $display("%0t: actual   kind=%0d byte=%h hdr=%b bad=%0d last=%b",
                     $time, out_tuser[1:0], out_tdata[BYTE_W-1:0], out_tuser[2],
                     out_tdata[OUT_DATA_W-1:BYTE_W], out_tlast);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Register writes, one per cycle; the shadow follows.
  task automatic write_reg(cfg_reg_t idx, byte_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_FIELD_SEP:    cfg_sh.sep = val;
      REG_QUOTE:        cfg_sh.quote = val;
      REG_ESCAPE:       cfg_sh.esc = val;
      REG_STRIP:        cfg_sh.strip = val[0];
      REG_DOUBLE_QUOTE: cfg_sh.dq = val[0];
      REG_BAD_IS_ERR:   cfg_sh.bad_err = val[0];
      REG_HEADER:       cfg_sh.header = val[0];
      default: begin
      end
    endcase
  endtask

  task automatic set_config(byte_t sep, byte_t quote, byte_t esc, logic strip, logic dq,
                            logic bad_err, logic header);
    write_reg(REG_FIELD_SEP, sep);
    write_reg(REG_QUOTE, quote);
    write_reg(REG_ESCAPE, esc);
    write_reg(REG_STRIP, {7'd0, strip});
    write_reg(REG_DOUBLE_QUOTE, {7'd0, dq});
    write_reg(REG_BAD_IS_ERR, {7'd0, bad_err});
    write_reg(REG_HEADER, {7'd0, header});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every byte is taken and every event has arrived, then lets the pipe settle.
  task automatic drain();
    do @(negedge clk);
    while (text_bytes.size() != 0 || in_tvalid || expected_events.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // A content byte that is none of the configured special bytes.
  function automatic byte_t plain_byte();
    byte_t c;
    do c = byte_t'($urandom_range(33, 126));
    while (c == cfg_sh.sep || c == cfg_sh.quote || c == cfg_sh.esc);
    return c;
  endfunction

  function automatic byte_t blank_byte();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic void push_blanks(int unsigned n);
    repeat (n) text_bytes.push_back(blank_byte());
  endfunction

  // One cell: plain, quoted, escaped or empty, with blanks before plain and quoted cells and after plain ones.
  function automatic void gen_cell();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(9);
    if (kind <= 4) begin
      push_blanks($urandom_range(3));
      n = $urandom_range(1, 5);
      repeat (n) begin
        case ($urandom_range(7))
          0: text_bytes.push_back(blank_byte());
          1: begin
            text_bytes.push_back(cfg_sh.esc);
            text_bytes.push_back(byte_t'($urandom_range(1, 255)));
          end
          default: text_bytes.push_back(plain_byte());
        endcase
      end
      // Long trailing runs push the blank hold past its depth.
      if ($urandom_range(4) == 0) push_blanks($urandom_range(8, 12));
      else push_blanks($urandom_range(3));
    end else if (kind <= 7) begin
      push_blanks($urandom_range(2));
      text_bytes.push_back(cfg_sh.quote);
      n = $urandom_range(6);
      repeat (n) begin
        case ($urandom_range(7))
          0: text_bytes.push_back(blank_byte());
          1: text_bytes.push_back(cfg_sh.sep);
          2: text_bytes.push_back($urandom_range(1) ? CH_NL : CH_CR);
          3: begin
            text_bytes.push_back(cfg_sh.quote);
            text_bytes.push_back(cfg_sh.quote);
          end
          4: begin
            text_bytes.push_back(cfg_sh.esc);
            text_bytes.push_back(byte_t'($urandom_range(0, 255)));
          end
          default: text_bytes.push_back(plain_byte());
        endcase
      end
      text_bytes.push_back(cfg_sh.quote);
      if ($urandom_range(9) == 0) text_bytes.push_back(plain_byte());
    end else if (kind == 8) begin
      // Empty cell.
    end else begin
      text_bytes.push_back(cfg_sh.esc);
      text_bytes.push_back(byte_t'($urandom_range(0, 255)));
    end
  endfunction

  // One row, a comment line, a blank line or a burst of arbitrary bytes.
  function automatic void gen_row();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) text_bytes.push_back(byte_t'($urandom_range(0, 255)));
      return;
    end
    if (pick < 14) begin
      text_bytes.push_back(CH_HASH);
      repeat ($urandom_range(5)) text_bytes.push_back(byte_t'($urandom_range(1, 255)));
      text_bytes.push_back(CH_NL);
      return;
    end
    if (pick < 18) begin
      text_bytes.push_back(CH_NL);
      return;
    end
    n = $urandom_range(1, 4);
    for (int unsigned i = 0; i < n; i++) begin
      if (i != 0) text_bytes.push_back(cfg_sh.sep);
      gen_cell();
    end
    pick = $urandom_range(99);
    if (pick < 40) begin
      text_bytes.push_back(CH_NL);
    end else if (pick < 60) begin
      text_bytes.push_back(CH_CR);
      text_bytes.push_back(CH_NL);
    end else if (pick < 70) begin
      text_bytes.push_back(CH_CR);
    end else if (pick < 85) begin
      text_bytes.push_back(CH_NUL);
    end else begin
      // End of input right after a line end counts a bad record.
      text_bytes.push_back(CH_NL);
      repeat ($urandom_range(1, 2)) text_bytes.push_back(CH_NUL);
    end
  endfunction

  function automatic void gen_text(int unsigned count);
    while (text_bytes.size() < count) gen_row();
  endfunction

  // Phases of configuration, idling and stimulus.
  initial begin
    byte_t opening[$];
    opening = {CH_HASH, "c", CH_NL,
               "a", ",", "\"", "x", "\"", "\"", "\"", CH_NL,
               CH_NL, CH_NUL, CH_NUL,
               "b", "\\", CH_NL, CH_NUL, "c", "\\", CH_NUL, CH_NUL,
               8'hFF, ",", CH_NUL};

    cfg_sh = '{sep: SEP_RST, quote: QUOTE_RST, esc: ESC_RST, strip: 1'b0, dq: 1'b1,
               bad_err: 1'b0, header: 1'b0};
    ps          = ST_START_FILE;
    first_row   = 1'b1;
    has_content = 1'b0;
    hold_cnt    = 0;
    bad_cnt     = '0;

    wait (rst_n);
    @(negedge clk);

    // Directed opening: comment, quoted cell with doubled quotes, bad records,
    // escaped line end, escape at end of input, top byte value.
    set_config(SEP_RST, QUOTE_RST, ESC_RST, 1'b0, 1'b1, 1'b1, 1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (opening[i]) text_bytes.push_back(opening[i]);
    drain();

    // Usual separators with stripping, sender idling.
    set_config(8'h2C, 8'h22, 8'h5C, 1'b1, 1'b1, 1'b0, 1'b0);
    send_idle_pct  = 54;
    recv_stall_pct = 0;
    gen_text(80);
    drain();

    // Single quotes closing without doubling, receiver stalling.
    set_config(8'h3B, 8'h27, 8'h2F, 1'b1, 1'b0, 1'b1, 1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 54;
    gen_text(80);
    drain();

    // Extreme special bytes, both sides idling.
    set_config(8'h01, 8'hFF, 8'h80, 1'b0, 1'b1, 1'b1, 1'b1);
    send_idle_pct  = 19;
    recv_stall_pct = 19;
    gen_text(70);
    drain();

    // Separator at the top, quote at the bottom, space as escape.
    set_config(8'hFF, 8'h01, CH_SPACE, 1'b1, 1'b1, 1'b0, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    gen_text(50);
    drain();

    // One byte for separator, quote and escape at once.
    set_config(8'h22, 8'h22, 8'h22, 1'b0, 1'b0, 1'b1, 1'b0);
    send_idle_pct  = 54;
    recv_stall_pct = 54;
    gen_text(40);
    drain();

    // Line end as separator, stripping with hold overflow, full throughput.
    set_config(CH_NL, 8'h22, 8'h5C, 1'b1, 1'b1, 1'b1, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    gen_text(40);
    drain();

    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/dtfp_pkg.sv
hdl/delimited_text_field_parser.sv
sim/delimited_text_field_parser_tb.sv
